@@ hw/rtl/bcc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

   localparam int SPRITE_ROWS  = 16;
   localparam int MAX_PLANES   = 8;
   localparam int FORM_W       = 16;
   localparam int FORM_DEPTH   = 2 * SPRITE_ROWS;
   localparam int FORM_AW      = $clog2(FORM_DEPTH);
   localparam int FROW_W       = $clog2(SPRITE_ROWS);
   localparam int ROWS_W       = FROW_W + 1;
   localparam int PLANE_W      = $clog2(MAX_PLANES);
   localparam int PCNT_W       = 4;
   localparam int COORD_W      = 12;
   localparam int HOT_W        = 4;
   localparam int COLOR_W      = 8;
   localparam int SHIFT_W      = 5;
   localparam int COL_W        = 8;

   // request tdata layout, lowest bit first
   localparam int REQ_DATA_W   = 80;
   localparam int REQ_IDX_LSB  = 0;
   localparam int REQ_WORD_LSB = 5;
   localparam int REQ_PX_LSB   = 21;
   localparam int REQ_PY_LSB   = 33;
   localparam int REQ_SL_LSB   = 45;
   localparam int REQ_SR_LSB   = 61;

   localparam int RSP_DATA_W   = 96;

   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 12;

   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_BEGIN = 2'd1,
      ACT_WORDS = 2'd2
   } bcc_action_type;

   typedef enum logic [1:0] {
      CLIP_NONE  = 2'd0,
      CLIP_LEFT  = 2'd1,
      CLIP_RIGHT = 2'd2
   } bcc_clip_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_HOT_X       = 3'd0,
      REG_HOT_Y       = 3'd1,
      REG_MAX_X       = 3'd2,
      REG_MAX_Y       = 3'd3,
      REG_BG_COLOR    = 3'd4,
      REG_FG_COLOR    = 3'd5,
      REG_PLANE_COUNT = 3'd6
   } bcc_reg_type;

   typedef enum logic [1:0] {
      KIND_BEGIN,
      KIND_WORDS,
      KIND_OVERRUN
   } bcc_kind_type;

   typedef struct packed {
      logic [HOT_W-1:0]   hot_x;
      logic [HOT_W-1:0]   hot_y;
      logic [COORD_W-1:0] max_x;
      logic [COORD_W-1:0] max_y;
      logic [COLOR_W-1:0] bg_color;
      logic [COLOR_W-1:0] fg_color;
      logic [PCNT_W-1:0]  plane_count;
   } bcc_cfg_type;

   // one request in flight between the control stage and the paint stage
   typedef struct packed {
      bcc_kind_type       kind;
      bcc_clip_type       mode;
      logic [ROWS_W-1:0]  rows;
      logic [COL_W-1:0]   column;
      logic [COORD_W-1:0] start_row;
      logic               last;
      logic [FORM_W-1:0]  left;
      logic [FORM_W-1:0]  right;
      logic               bg_bit;
      logic               fg_bit;
      logic [SHIFT_W-1:0] shift;
   } bcc_stage_type;

endpackage

`default_nettype wire

@@ hw/rtl/bitplane_cursor_compositor.sv @@
// A begin or words request is registered in the control stage, then in the response register.
// Throughput: one request per cycle unless the response side stalls; the form store read for
// the next plane row is registered as the request is taken; painting is one shift and mask step.
// Reset: registers return to their defaults, any run ends and the pipeline empties;
// the form store is not cleared and must be loaded before use.
`timescale 1ns / 1ps
`default_nettype none

module bitplane_cursor_compositor import bcc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // mask_index[4:0], mask_word[20:5], pos_x[32:21], pos_y[44:33],
   // screen_left[60:45], screen_right[76:61], zero pad[79:77]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // action[1:0]
   input  wire logic [1:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // save_left[15:0], save_right[31:16], new_left[47:32], new_right[63:48],
   // write_left[64], write_right[65], clip_mode[67:66], cursor_rows[72:68],
   // word_column[80:73], start_row[92:81], zero pad[95:93]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // last
   output logic                       rsp_tlast,
   // overrun
   output logic                       rsp_tuser,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   bcc_cfg_type        cfg;
   logic               s1_ready;
   logic               s1_valid;
   bcc_stage_type      s1_data;
   logic               mem_wr_en;
   logic [FORM_AW-1:0] mem_wr_addr;
   logic [FORM_W-1:0]  mem_wr_data;
   logic               mem_rd_en;
   logic [FORM_AW-1:0] mem_rd_addr_bg;
   logic [FORM_AW-1:0] mem_rd_addr_fg;
   logic [FORM_W-1:0]  form_bg;
   logic [FORM_W-1:0]  form_fg;

   bcc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bcc_form_store u_form_store (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data),
      .rd_en      (mem_rd_en),
      .rd_addr_bg (mem_rd_addr_bg),
      .rd_addr_fg (mem_rd_addr_fg),
      .rd_bg      (form_bg),
      .rd_fg      (form_fg)
   );

   bcc_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .s1_ready       (s1_ready),
      .s1_valid       (s1_valid),
      .s1_data        (s1_data),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr_bg (mem_rd_addr_bg),
      .mem_rd_addr_fg (mem_rd_addr_fg)
   );

   bcc_paint u_paint (
      .clock      (clock),
      .reset      (reset),
      .s1_valid   (s1_valid),
      .s1_data    (s1_data),
      .form_bg    (form_bg),
      .form_fg    (form_fg),
      .s1_ready   (s1_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

@@ hw/rtl/bcc_csr.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bcc_csr import bcc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output bcc_cfg_type                cfg
);

   bcc_cfg_type cfg_ff;
   bcc_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_HOT_X:       cfg_in.hot_x       = csr_data[HOT_W-1:0];
            REG_HOT_Y:       cfg_in.hot_y       = csr_data[HOT_W-1:0];
            REG_MAX_X:       cfg_in.max_x       = csr_data[COORD_W-1:0];
            REG_MAX_Y:       cfg_in.max_y       = csr_data[COORD_W-1:0];
            REG_BG_COLOR:    cfg_in.bg_color    = csr_data[COLOR_W-1:0];
            REG_FG_COLOR:    cfg_in.fg_color    = csr_data[COLOR_W-1:0];
            REG_PLANE_COUNT: cfg_in.plane_count = csr_data[PCNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hot_x       <= '0;
         cfg_ff.hot_y       <= '0;
         cfg_ff.max_x       <= COORD_W'(639);
         cfg_ff.max_y       <= COORD_W'(399);
         cfg_ff.bg_color    <= '0;
         cfg_ff.fg_color    <= COLOR_W'(1);
         cfg_ff.plane_count <= PCNT_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/bcc_form_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bcc_form_store import bcc_pkg::*; (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [FORM_AW-1:0] wr_addr,
   input  wire logic [FORM_W-1:0]  wr_data,
   input  wire logic               rd_en,
   input  wire logic [FORM_AW-1:0] rd_addr_bg,
   input  wire logic [FORM_AW-1:0] rd_addr_fg,
   output logic [FORM_W-1:0]       rd_bg,
   output logic [FORM_W-1:0]       rd_fg
);

   logic [FORM_W-1:0] mem [FORM_DEPTH];
   logic [FORM_W-1:0] rd_bg_ff;
   logic [FORM_W-1:0] rd_fg_ff;

   assign rd_bg = rd_bg_ff;
   assign rd_fg = rd_fg_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_bg_ff <= mem[rd_addr_bg];
         rd_fg_ff <= mem[rd_addr_fg];
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/bcc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bcc_ctrl import bcc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bcc_cfg_type           cfg,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [1:0]            req_tuser,
   input  wire logic                  s1_ready,
   output logic                       s1_valid,
   output bcc_stage_type              s1_data,
   output logic                       mem_wr_en,
   output logic [FORM_AW-1:0]         mem_wr_addr,
   output logic [FORM_W-1:0]          mem_wr_data,
   output logic                       mem_rd_en,
   output logic [FORM_AW-1:0]         mem_rd_addr_bg,
   output logic [FORM_AW-1:0]         mem_rd_addr_fg
);

   // run state
   bcc_clip_type       mode_ff,      mode_in;
   logic [ROWS_W-1:0]  rows_ff,      rows_in;
   logic [FROW_W-1:0]  ffr_ff,       ffr_in;
   logic [SHIFT_W-1:0] shift_ff,     shift_in;
   logic [ROWS_W-1:0]  row_cnt_ff,   row_cnt_in;
   logic [PLANE_W-1:0] plane_cnt_ff, plane_cnt_in;
   logic [PCNT_W-1:0]  planes_ff,    planes_in;
   logic               active_ff,    active_in;

   logic               s1_valid_ff, s1_valid_in;
   bcc_stage_type      s1_data_ff,  s1_data_in;

   logic               accept;
   bcc_action_type     action;
   logic [COORD_W-1:0] pos_x;
   logic [COORD_W-1:0] pos_y;
   logic [FORM_W-1:0]  scr_left;
   logic [FORM_W-1:0]  scr_right;

   logic signed [COORD_W:0] x_diff;
   logic signed [COORD_W:0] x_lim;
   logic signed [COORD_W:0] y_diff;
   logic signed [COORD_W:0] y_lim;
   logic signed [COORD_W:0] y_rows;
   logic [COORD_W:0]        x_adj;
   bcc_clip_type            b_mode;
   logic [ROWS_W-1:0]       b_rows;
   logic [FROW_W-1:0]       b_ffr;
   logic [COORD_W-1:0]      b_start;
   logic [PCNT_W-1:0]       b_planes;

   logic [FROW_W-1:0]       frow;
   logic [ROWS_W-1:0]       row_next;
   logic [PCNT_W-1:0]       plane_next;
   logic                    row_wrap;
   logic                    run_end;

   assign req_tready = s1_ready;
   assign accept     = req_tvalid & req_tready;
   assign action     = bcc_action_type'(req_tuser);
   assign pos_x      = req_tdata[REQ_PX_LSB +: COORD_W];
   assign pos_y      = req_tdata[REQ_PY_LSB +: COORD_W];
   assign scr_left   = req_tdata[REQ_SL_LSB +: FORM_W];
   assign scr_right  = req_tdata[REQ_SR_LSB +: FORM_W];

   assign mem_wr_en   = accept && (action == ACT_LOAD);
   assign mem_wr_addr = req_tdata[REQ_IDX_LSB +: FORM_AW];
   assign mem_wr_data = req_tdata[REQ_WORD_LSB +: FORM_W];

   // form row wraps within the sprite
   assign frow           = ffr_ff + row_cnt_ff[FROW_W-1:0];
   assign mem_rd_addr_bg = {frow, 1'b0};
   assign mem_rd_addr_fg = {frow, 1'b1};
   assign mem_rd_en      = accept && (action == ACT_WORDS) && active_ff;

   assign row_next   = row_cnt_ff + ROWS_W'(1);
   assign row_wrap   = row_next >= rows_ff;
   assign plane_next = PCNT_W'(plane_cnt_ff) + PCNT_W'(1);
   assign run_end    = row_wrap && (plane_next >= planes_ff);

   // begin: hot spot adjust, clip, visible rows and plane count clamp
   always_comb begin
      x_diff  = $signed({1'b0, pos_x}) - $signed({{(COORD_W-HOT_W+1){1'b0}}, cfg.hot_x});
      x_lim   = $signed({1'b0, cfg.max_x}) - 13'sd15;
      y_diff  = $signed({1'b0, pos_y}) - $signed({{(COORD_W-HOT_W+1){1'b0}}, cfg.hot_y});
      y_lim   = $signed({1'b0, cfg.max_y}) - 13'sd15;
      y_rows  = $signed({1'b0, cfg.max_y}) - y_diff + 13'sd1;
      x_adj   = x_diff;
      b_ffr   = '0;
      b_start = y_diff[COORD_W-1:0];
      if (x_diff[COORD_W]) begin
         x_adj  = x_diff + 13'sd16;
         b_mode = CLIP_LEFT;
      end else if (x_diff >= x_lim) begin
         b_mode = CLIP_RIGHT;
      end else begin
         b_mode = CLIP_NONE;
      end
      if (y_diff[COORD_W]) begin
         b_rows  = ROWS_W'(SPRITE_ROWS) + y_diff[ROWS_W-1:0];
         b_ffr   = FROW_W'(-y_diff[FROW_W-1:0]);
         b_start = '0;
      end else if (y_diff > y_lim) begin
         b_rows = (y_rows > 13'sd0) ? y_rows[ROWS_W-1:0] : '0;
      end else begin
         b_rows = ROWS_W'(SPRITE_ROWS);
      end
      b_planes = (cfg.plane_count > PCNT_W'(MAX_PLANES)) ? PCNT_W'(MAX_PLANES)
                                                        : cfg.plane_count;
   end

   always_comb begin
      mode_in      = mode_ff;
      rows_in      = rows_ff;
      ffr_in       = ffr_ff;
      shift_in     = shift_ff;
      row_cnt_in   = row_cnt_ff;
      plane_cnt_in = plane_cnt_ff;
      planes_in    = planes_ff;
      active_in    = active_ff;
      s1_valid_in  = s1_valid_ff && !s1_ready;
      s1_data_in   = s1_data_ff;

      if (accept) begin
         s1_data_in.kind      = KIND_OVERRUN;
         s1_data_in.mode      = mode_ff;
         s1_data_in.rows      = rows_ff;
         s1_data_in.column    = '0;
         s1_data_in.start_row = '0;
         s1_data_in.last      = 1'b0;
         s1_data_in.left      = scr_left;
         s1_data_in.right     = scr_right;
         s1_data_in.bg_bit    = cfg.bg_color[plane_cnt_ff];
         s1_data_in.fg_bit    = cfg.fg_color[plane_cnt_ff];
         s1_data_in.shift     = shift_ff;

         case (action)
            ACT_BEGIN: begin
               mode_in      = b_mode;
               rows_in      = b_rows;
               ffr_in       = b_ffr;
               shift_in     = SHIFT_W'(SPRITE_ROWS) - SHIFT_W'(x_adj[3:0]);
               row_cnt_in   = '0;
               plane_cnt_in = '0;
               planes_in    = b_planes;
               active_in    = (b_rows != '0) && (b_planes != '0);
               s1_valid_in  = 1'b1;
               s1_data_in.kind      = KIND_BEGIN;
               s1_data_in.mode      = b_mode;
               s1_data_in.rows      = b_rows;
               s1_data_in.column    = x_adj[COORD_W-1:4];
               s1_data_in.start_row = b_start;
            end
            ACT_WORDS: begin
               s1_valid_in = 1'b1;
               if (active_ff) begin
                  s1_data_in.kind = KIND_WORDS;
                  s1_data_in.last = run_end;
                  // advance row, then plane; drop the run after the last plane
                  if (row_wrap) begin
                     row_cnt_in = '0;
                     if (run_end) begin
                        plane_cnt_in = '0;
                        active_in    = 1'b0;
                     end else begin
                        plane_cnt_in = plane_next[PLANE_W-1:0];
                     end
                  end else begin
                     row_cnt_in = row_next;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= CLIP_NONE;
         rows_ff      <= '0;
         ffr_ff       <= '0;
         shift_ff     <= '0;
         row_cnt_ff   <= '0;
         plane_cnt_ff <= '0;
         planes_ff    <= '0;
         active_ff    <= 1'b0;
         s1_valid_ff  <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         rows_ff      <= rows_in;
         ffr_ff       <= ffr_in;
         shift_ff     <= shift_in;
         row_cnt_ff   <= row_cnt_in;
         plane_cnt_ff <= plane_cnt_in;
         planes_ff    <= planes_in;
         active_ff    <= active_in;
         s1_valid_ff  <= s1_valid_in;
      end
      s1_data_ff <= s1_data_in;
   end

   assign s1_valid = s1_valid_ff;
   assign s1_data  = s1_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/bcc_paint.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bcc_paint import bcc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  s1_valid,
   input  wire bcc_stage_type         s1_data,
   input  wire logic [FORM_W-1:0]     form_bg,
   input  wire logic [FORM_W-1:0]     form_fg,
   output logic                       s1_ready,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast,
   output logic                       rsp_tuser
);

   localparam int PIX_W = 2 * FORM_W;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff,  rsp_data_in;
   logic                  rsp_last_ff,  rsp_last_in;
   logic                  rsp_user_ff,  rsp_user_in;

   logic                  out_free;
   logic                  advance;
   logic [PIX_W-1:0]      bg_sh;
   logic [PIX_W-1:0]      fg_sh;
   logic [PIX_W-1:0]      bits_bg;
   logic [PIX_W-1:0]      bits;
   logic [FORM_W-1:0]     save_left;
   logic [FORM_W-1:0]     save_right;
   logic [FORM_W-1:0]     new_left;
   logic [FORM_W-1:0]     new_right;
   logic                  write_left;
   logic                  write_right;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign s1_ready = !s1_valid || out_free;
   assign advance  = s1_valid && out_free;

   // background first, then foreground over it
   always_comb begin
      bg_sh   = PIX_W'(form_bg) << s1_data.shift;
      fg_sh   = PIX_W'(form_fg) << s1_data.shift;
      bits_bg = {s1_data.left, s1_data.right};
      bits_bg = s1_data.bg_bit ? (bits_bg | bg_sh) : (bits_bg & ~bg_sh);
      bits    = s1_data.fg_bit ? (bits_bg | fg_sh) : (bits_bg & ~fg_sh);
   end

   always_comb begin
      save_left   = '0;
      save_right  = '0;
      new_left    = '0;
      new_right   = '0;
      write_left  = 1'b0;
      write_right = 1'b0;
      if (s1_data.kind == KIND_WORDS) begin
         case (s1_data.mode)
            CLIP_LEFT: begin
               save_right  = s1_data.right;
               new_right   = bits[FORM_W-1:0];
               write_right = 1'b1;
            end
            CLIP_RIGHT: begin
               save_left  = s1_data.left;
               new_left   = bits[PIX_W-1:FORM_W];
               write_left = 1'b1;
            end
            default: begin
               save_left   = s1_data.left;
               save_right  = s1_data.right;
               new_left    = bits[PIX_W-1:FORM_W];
               new_right   = bits[FORM_W-1:0];
               write_left  = 1'b1;
               write_right = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = (s1_data.kind == KIND_OVERRUN);
         rsp_last_in  = s1_data.last;
         if (s1_data.kind == KIND_OVERRUN) begin
            rsp_data_in = '0;
         end else begin
            rsp_data_in = RSP_DATA_W'({s1_data.start_row, s1_data.column, s1_data.rows,
                                       s1_data.mode, write_right, write_left,
                                       new_right, new_left, save_right, save_left});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

@@ verif/bitplane_cursor_compositor_tb.sv @@
`timescale 1ns / 1ps

module bitplane_cursor_compositor_tb;
   import bcc_pkg::*;

   localparam logic [1:0] ACT_SPARE = 2'd3;
   localparam int REQ_USED_W   = REQ_SR_LSB + FORM_W;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 250;
   localparam int DRAIN_CYCLES = 6;
   localparam int PHASE_ITEMS  = 150;

   typedef struct {
      logic [FORM_W-1:0]  save_left;
      logic [FORM_W-1:0]  save_right;
      logic [FORM_W-1:0]  new_left;
      logic [FORM_W-1:0]  new_right;
      logic               write_left;
      logic               write_right;
      logic [1:0]         clip_mode;
      logic [ROWS_W-1:0]  cursor_rows;
      logic [COL_W-1:0]   word_column;
      logic [COORD_W-1:0] start_row;
      logic               last;
      logic               overrun;
   } blit_result_type;

   class cursor_blit_tracker;
      int hot_x, hot_y, max_x, max_y, plane_count;
      logic [COLOR_W-1:0] bg_color, fg_color;
      logic [FORM_W-1:0] form [FORM_DEPTH];
      bcc_clip_type mode;
      int rows_visible, first_row, shift, row_ctr, plane_ctr, planes;
      bit run_on;
      blit_result_type blits_due [$];
      int errors, checked, begins, runs_done, overruns, requests;

      function new();
         max_x = 639;
         max_y = 399;
         bg_color = '0;
         fg_color = 8'h01;
         plane_count = 1;
         mode = CLIP_NONE;
         foreach (form[i]) form[i] = '0;
      endfunction

      function int pending();
         return blits_due.size();
      endfunction

      function void set_reg(bcc_reg_type idx, int value);
         int v;
         v = value & 'hfff;
         case (idx)
            REG_HOT_X:       hot_x = v & 'hf;
            REG_HOT_Y:       hot_y = v & 'hf;
            REG_MAX_X:       max_x = v;
            REG_MAX_Y:       max_y = v;
            REG_BG_COLOR:    bg_color = v[COLOR_W-1:0];
            REG_FG_COLOR:    fg_color = v[COLOR_W-1:0];
            REG_PLANE_COUNT: plane_count = v & 'hf;
            default: ;
         endcase
      endfunction

      // background first, then foreground; the plane's color bit picks set or clear
      function logic [31:0] paint(logic [31:0] bits, int frow);
         logic [31:0] bg, fg;
         int idx;
         idx = (2 * frow) & (FORM_DEPTH - 1);
         bg = {16'h0, form[idx]} << shift;
         fg = {16'h0, form[idx + 1]} << shift;
         if (bg_color[plane_ctr]) bits = bits | bg;
         else bits = bits & ~bg;
         if (fg_color[plane_ctr]) bits = bits | fg;
         else bits = bits & ~fg;
         return bits;
      endfunction

      function void take_request(logic [1:0] act, logic [REQ_DATA_W-1:0] d);
         blit_result_type r;
         int x, y, nrows;
         logic [FORM_W-1:0] sl, sr;
         logic [31:0] bits;
         r = '{default: '0};
         sl = d[REQ_SL_LSB +: FORM_W];
         sr = d[REQ_SR_LSB +: FORM_W];
         if (act != ACT_SPARE) requests++;
         case (act)
            ACT_LOAD: form[d[REQ_IDX_LSB +: FORM_AW]] = d[REQ_WORD_LSB +: FORM_W];
            ACT_BEGIN: begin
               x = int'(d[REQ_PX_LSB +: COORD_W]) - hot_x;
               y = int'(d[REQ_PY_LSB +: COORD_W]) - hot_y;
               if (x < 0) begin
                  x += 16;
                  mode = CLIP_LEFT;
               end else if (x >= max_x - 15) mode = CLIP_RIGHT;
               else mode = CLIP_NONE;
               first_row = 0;
               if (y < 0) begin
                  nrows = y + 16;
                  first_row = -y;
                  y = 0;
               end else if (y > max_y - 15) nrows = max_y - y + 1;
               else nrows = SPRITE_ROWS;
               if (nrows < 0) nrows = 0;
               rows_visible = nrows;
               shift = 16 - (x & 15);
               row_ctr = 0;
               plane_ctr = 0;
               planes = (plane_count > MAX_PLANES) ? MAX_PLANES : plane_count;
               run_on = (rows_visible > 0) && (planes > 0);
               r.clip_mode = mode;
               r.cursor_rows = ROWS_W'(rows_visible);
               r.word_column = COL_W'(x >> 4);
               r.start_row = COORD_W'(y);
               begins++;
               blits_due.push_back(r);
            end
            ACT_WORDS: begin
               if (!run_on) begin
                  r.overrun = 1'b1;
                  overruns++;
               end else begin
                  case (mode)
                     CLIP_NONE: begin
                        bits = paint({sl, sr}, first_row + row_ctr);
                        r.save_left = sl;
                        r.save_right = sr;
                        r.new_left = bits[31:16];
                        r.new_right = bits[15:0];
                        r.write_left = 1'b1;
                        r.write_right = 1'b1;
                     end
                     CLIP_LEFT: begin
                        bits = paint({16'h0, sr}, first_row + row_ctr);
                        r.save_right = sr;
                        r.new_right = bits[15:0];
                        r.write_right = 1'b1;
                     end
                     default: begin
                        bits = paint({sl, 16'h0}, first_row + row_ctr);
                        r.save_left = sl;
                        r.new_left = bits[31:16];
                        r.write_left = 1'b1;
                     end
                  endcase
                  r.clip_mode = mode;
                  r.cursor_rows = ROWS_W'(rows_visible);
                  // advance row, then plane; the final plane row closes the run
                  row_ctr++;
                  if (row_ctr >= rows_visible) begin
                     row_ctr = 0;
                     plane_ctr++;
                     if (plane_ctr >= planes) begin
                        plane_ctr = 0;
                        run_on = 1'b0;
                        r.last = 1'b1;
                        runs_done++;
                     end
                  end
               end
               blits_due.push_back(r);
            end
            default: ;
         endcase
      endfunction

      function bit differs(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void check_response(blit_result_type got);
         blit_result_type want;
         bit bad;
         if (blits_due.size() == 0) begin
            $display("%0t: response with nothing expected: save %h/%h new %h/%h",
                     $time, got.save_left, got.save_right, got.new_left, got.new_right);
            $display("%0t:    clip %0d last %b overrun %b",
                     $time, got.clip_mode, got.last, got.overrun);
            errors++;
            return;
         end
         want = blits_due.pop_front();
         checked++;
         bad = 1'b0;
         bad |= differs("save_left", 32'(want.save_left), 32'(got.save_left));
         bad |= differs("save_right", 32'(want.save_right), 32'(got.save_right));
         bad |= differs("new_left", 32'(want.new_left), 32'(got.new_left));
         bad |= differs("new_right", 32'(want.new_right), 32'(got.new_right));
         bad |= differs("write_left", 32'(want.write_left), 32'(got.write_left));
         bad |= differs("write_right", 32'(want.write_right), 32'(got.write_right));
         bad |= differs("clip_mode", 32'(want.clip_mode), 32'(got.clip_mode));
         bad |= differs("cursor_rows", 32'(want.cursor_rows), 32'(got.cursor_rows));
         bad |= differs("word_column", 32'(want.word_column), 32'(got.word_column));
         bad |= differs("start_row", 32'(want.start_row), 32'(got.start_row));
         bad |= differs("last", 32'(want.last), 32'(got.last));
         bad |= differs("overrun", 32'(want.overrun), 32'(got.overrun));
         if (bad) errors++;
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // mask_index, mask_word, pos_x, pos_y, screen_left, screen_right, zero pad
   logic [REQ_DATA_W-1:0] req_tdata;
   // action
   logic [1:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // save_left, save_right, new_left, new_right, write_left, write_right,
   // clip_mode, cursor_rows, word_column, start_row, zero pad
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // last
   logic                  rsp_tlast;
   // overrun
   logic                  rsp_tuser;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   cursor_blit_tracker tracker = new();
   int req_idle_pct = 31;
   int rsp_idle_pct = 31;
   int cycle_count = 0;
   bit hold_req = 1'b0;

   bitplane_cursor_compositor u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      while (cycle_count <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles with %0d responses outstanding",
               cycle_count, tracker.pending());
      $display("CHECKS FAILED");
      $finish;
   end

   // response ready: random stalls, or one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   initial begin
      blit_result_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.save_left   = rsp_tdata[15:0];
            got.save_right  = rsp_tdata[31:16];
            got.new_left    = rsp_tdata[47:32];
            got.new_right   = rsp_tdata[63:48];
            got.write_left  = rsp_tdata[64];
            got.write_right = rsp_tdata[65];
            got.clip_mode   = rsp_tdata[67:66];
            got.cursor_rows = rsp_tdata[72:68];
            got.word_column = rsp_tdata[80:73];
            got.start_row   = rsp_tdata[92:81];
            got.last        = rsp_tlast;
            got.overrun     = rsp_tuser;
            tracker.check_response(got);
         end
      end
   end

   function automatic logic [REQ_DATA_W-1:0] noise_item();
      logic [95:0] r;
      r = {$urandom, $urandom, $urandom};
      r[95:REQ_USED_W] = '0;
      return r[REQ_DATA_W-1:0];
   endfunction

   // coordinate near the low edge, near the far edge, or anywhere
   function automatic int pick_coord(int lim, int hot);
      int lo, hi;
      case ($urandom_range(3))
         0: return $urandom_range(20);
         3: return $urandom_range(4095);
         default: begin
            lo = lim + hot - 20;
            hi = lim + hot + 4;
            if (lo < 0) lo = 0;
            if (hi > 4095) hi = 4095;
            return $urandom_range(hi, lo);
         end
      endcase
   endfunction

   // leaves tvalid high after the handshake; the next caller drives it
   task automatic send_item(logic [1:0] act, logic [REQ_DATA_W-1:0] data);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
      tracker.take_request(act, data);
   endtask

   task automatic send_load(int idx, int word);
      logic [REQ_DATA_W-1:0] data;
      data = noise_item();
      data[REQ_IDX_LSB +: FORM_AW] = FORM_AW'(idx);
      data[REQ_WORD_LSB +: FORM_W] = FORM_W'(word);
      send_item(ACT_LOAD, data);
   endtask

   task automatic send_begin(int px, int py);
      logic [REQ_DATA_W-1:0] data;
      data = noise_item();
      data[REQ_PX_LSB +: COORD_W] = COORD_W'(px);
      data[REQ_PY_LSB +: COORD_W] = COORD_W'(py);
      send_item(ACT_BEGIN, data);
   endtask

   task automatic send_words();
      send_item(ACT_WORDS, noise_item());
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      // a trailing load gives no response; let it drain too
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(bcc_reg_type idx, int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      tracker.set_reg(idx, value);
   endtask

   task automatic apply_setting(int hx, int hy, int mx, int my, int bg, int fg, int pc);
      settle();
      write_csr(REG_HOT_X, hx);
      write_csr(REG_HOT_Y, hy);
      write_csr(REG_MAX_X, mx);
      write_csr(REG_MAX_Y, my);
      write_csr(REG_BG_COLOR, bg);
      write_csr(REG_FG_COLOR, fg);
      write_csr(REG_PLANE_COUNT, pc);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(int target);
      int sent, pick;
      sent = 0;
      while (sent < target) begin
         pick = $urandom_range(99);
         if (pick < 85) begin
            send_begin(pick_coord(tracker.max_x, tracker.hot_x),
                       pick_coord(tracker.max_y, tracker.hot_y));
            sent++;
            while (tracker.run_on) begin
               pick = $urandom_range(999);
               if (pick < 40) begin
                  send_load($urandom_range(FORM_DEPTH - 1), $urandom_range(65535));
                  sent++;
               end else if (pick < 60) begin
                  send_item(ACT_SPARE, noise_item());
               end else if (pick == 60) begin
                  // stop feeding the run here; later words or the next begin pick it up
                  break;
               end else begin
                  send_words();
                  sent++;
               end
            end
         end else if (pick < 93) begin
            send_words();
            sent++;
         end else if (pick < 97) begin
            send_load($urandom_range(FORM_DEPTH - 1), $urandom_range(65535));
            sent++;
         end else begin
            send_item(ACT_SPARE, noise_item());
         end
      end
   endtask

   initial begin
      int ph;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fill the whole form store before anything can read it
      for (int i = 0; i < FORM_DEPTH; i++) send_load(i, $urandom_range(65535));

      apply_setting(5, 3, 639, 399, 8'haa, 8'h55, 2);
      send_words();
      send_item(ACT_SPARE, noise_item());
      send_begin(2, 402);
      send_words();
      send_words();
      send_begin(640, 401);
      send_words();
      send_begin(21, 402);
      send_words();
      send_load(1, 16'hffff);
      send_words();
      send_begin(4095, 4095);
      send_words();
      send_begin(0, 0);
      send_words();
      send_words();
      send_begin(18, 200);
      send_words();

      apply_setting(0, 0, 4095, 4095, 8'h00, 8'hff, 0);
      send_begin(300, 100);
      send_words();

      apply_setting(15, 15, 15, 15, 8'h0f, 8'hf0, 12);
      send_begin(3, 30);
      repeat (MAX_PLANES) send_words();

      for (ph = 0; ph < 6; ph++) begin
         case (ph)
            0: apply_setting(0, 0, 639, 399, 8'h00, 8'h01, 4);
            1: apply_setting(15, 15, 15, 15, 8'hff, 8'h00, 8);
            2: apply_setting($urandom_range(15), $urandom_range(15), 4095, 4095,
                             $urandom_range(255), $urandom_range(255), 12);
            3: apply_setting($urandom_range(15), $urandom_range(15),
                             $urandom_range(4095, 15), $urandom_range(4095, 15),
                             $urandom_range(255), $urandom_range(255),
                             $urandom_range(MAX_PLANES, 1));
            4: apply_setting(7, 2, 1023, 767, $urandom_range(255), $urandom_range(255), 1);
            default: apply_setting($urandom_range(15), $urandom_range(15),
                                   $urandom_range(4095, 15), $urandom_range(4095, 15),
                                   $urandom_range(255), $urandom_range(255), 2);
         endcase
         if (ph == 0 || ph == 3) hold_req = 1'b1;
         req_idle_pct = (ph == 4) ? 0 : 31;
         rsp_idle_pct = (ph == 4) ? 0 : 31;
         random_phase(PHASE_ITEMS);
      end

      settle();
      $display("Sent %0d requests: %0d begins, %0d runs painted to the final plane row,",
               tracker.requests, tracker.begins, tracker.runs_done);
      $display("%0d overruns; checked %0d responses across nine register settings.",
               tracker.overruns, tracker.checked);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d bad responses, %0d never arrived", tracker.errors, tracker.pending());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/bcc_pkg.sv
hw/rtl/bcc_csr.sv
hw/rtl/bcc_form_store.sv
hw/rtl/bcc_ctrl.sv
hw/rtl/bcc_paint.sv
hw/rtl/bitplane_cursor_compositor.sv
verif/bitplane_cursor_compositor_tb.sv
